/* hw/rtl/wwlb_pkg.sv */
package wwlb_pkg;

    localparam int unsigned MAX_TEXT_BYTES = 65535;
    localparam logic [15:0] OFFSET_LIMIT =
        (MAX_TEXT_BYTES < 65535) ? 16'(MAX_TEXT_BYTES) : 16'hFFFF;

    localparam logic [20:0] CH_NEWLINE = 21'd10;
    localparam logic [20:0] CH_SPACE   = 21'd32;

    localparam logic REG_WRAP_ENABLE = 1'b0;
    localparam logic REG_LINE_WIDTH  = 1'b1;

    localparam logic       WRAP_ENABLE_RESET = 1'b1;
    localparam logic [7:0] LINE_WIDTH_RESET  = 8'd80;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [20:0] char_code;
        logic [2:0]  byte_count;
        logic        end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [15:0] line_end;
        logic [15:0] line_number;
        logic        final_line;
        logic        last_result;
    } out_item_t;

    // results produced by one word: count is 0, 1 or 2
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

endpackage

/* hw/rtl/wwlb_core.sv */
module wwlb_core #(
    parameter int unsigned MAX_TEXT_BYTES = wwlb_pkg::MAX_TEXT_BYTES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  wwlb_pkg::in_item_t item,
    input  logic               wrap_enable,
    input  logic [7:0]         line_width,
    output wwlb_pkg::push_t    push
);
    import wwlb_pkg::*;

    localparam logic [15:0] OFF_LIMIT =
        (MAX_TEXT_BYTES < 65535) ? 16'(MAX_TEXT_BYTES) : 16'hFFFF;

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [7:0]  column_reg, column_next;
    logic        space_seen_reg, space_seen_next;
    logic [15:0] space_offset_reg, space_offset_next;
    logic [7:0]  space_column_reg, space_column_next;
    logic [15:0] line_count_reg, line_count_next;

    always_comb
    begin
        logic [2:0]  nb;
        logic [16:0] sum;
        logic [15:0] step_end;
        logic [7:0]  last_col;
        logic        is_space;
        logic        eff_seen;
        logic [15:0] eff_off;
        logic [7:0]  eff_col;
        logic [7:0]  carried;
        logic        closes;
        logic [15:0] close_end;
        logic        open;
        logic [15:0] lc_inc;

        nb = item.byte_count;
        if (nb == 3'd0)
            nb = 3'd1;
        else if (nb > 3'd4)
            nb = 3'd4;
        sum = {1'b0, byte_offset_reg} + 17'(nb);
        step_end = (sum > {1'b0, OFF_LIMIT}) ? OFF_LIMIT : sum[15:0];
        // zero width behaves as one column
        last_col = (line_width == 8'd0) ? 8'd0 : line_width - 8'd1;
        lc_inc = (line_count_reg == 16'hFFFF) ? line_count_reg : line_count_reg + 16'd1;

        is_space = (item.char_code == CH_SPACE);
        eff_seen = space_seen_reg | is_space;
        eff_off  = is_space ? step_end : space_offset_reg;
        eff_col  = is_space ? column_reg : space_column_reg;
        carried  = (column_reg >= eff_col) ? column_reg - eff_col : 8'd0;

        closes            = 1'b0;
        close_end         = step_end;
        open              = 1'b1;
        column_next       = column_reg;
        space_seen_next   = space_seen_reg;
        space_offset_next = space_offset_reg;
        space_column_next = space_column_reg;

        if (item.char_code == CH_NEWLINE)
        begin
            closes          = 1'b1;
            column_next     = 8'd0;
            space_seen_next = 1'b0;
            open            = 1'b0;
        end
        else if (wrap_enable)
        begin
            space_offset_next = eff_off;
            space_column_next = eff_col;
            if (column_reg >= last_col)
            begin
                closes          = 1'b1;
                space_seen_next = 1'b0;
                if (eff_seen)
                begin
                    // break after the last space, the rest moves down
                    close_end   = eff_off;
                    column_next = carried;
                    open        = (carried != 8'd0);
                end
                else
                begin
                    column_next = 8'd0;
                    open        = 1'b0;
                end
            end
            else
            begin
                space_seen_next = eff_seen;
                column_next     = column_reg + 8'd1;
            end
        end
        else if (column_reg != 8'hFF)
        begin
            column_next = column_reg + 8'd1;
        end

        push.first.line_end     = closes ? close_end : step_end;
        push.first.line_number  = line_count_reg;
        push.first.final_line   = item.end_of_text && !(closes && open);
        push.first.last_result  = !(item.end_of_text && closes && open);
        push.second.line_end    = step_end;
        push.second.line_number = lc_inc;
        push.second.final_line  = 1'b1;
        push.second.last_result = 1'b1;

        if (closes && item.end_of_text && open)
            push.count = 2'd2;
        else if (closes || item.end_of_text)
            push.count = 2'd1;
        else
            push.count = 2'd0;
        if (!fire)
            push.count = 2'd0;

        byte_offset_next = step_end;
        line_count_next  = closes ? lc_inc : line_count_reg;

        // end of text starts the next text from scratch
        if (item.end_of_text)
        begin
            byte_offset_next  = 16'd0;
            column_next       = 8'd0;
            space_seen_next   = 1'b0;
            space_offset_next = 16'd0;
            space_column_next = 8'd0;
            line_count_next   = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg  <= 16'd0;
            column_reg       <= 8'd0;
            space_seen_reg   <= 1'b0;
            space_offset_reg <= 16'd0;
            space_column_reg <= 8'd0;
            line_count_reg   <= 16'd0;
        end
        else if (fire)
        begin
            byte_offset_reg  <= byte_offset_next;
            column_reg       <= column_next;
            space_seen_reg   <= space_seen_next;
            space_offset_reg <= space_offset_next;
            space_column_reg <= space_column_next;
            line_count_reg   <= line_count_next;
        end
    end

endmodule

/* hw/rtl/wwlb_out_queue.sv */
module wwlb_out_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  wwlb_pkg::push_t     push,
    output logic                room,
    output logic                out_valid,
    input  logic                out_stall,
    output wwlb_pkg::out_item_t out_data
);
    import wwlb_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);

    out_item_t       mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]     count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    // space for the two results one word can close
    assign room      = (count_reg <= (PW+1)'(QUEUE_DEPTH - 2));

    assign count_next = count_reg + (PW+1)'(push.count) - (PW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem[wr_ptr_reg + PW'(1)] <= push.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push.count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_next;
        end
    end

endmodule

/* hw/rtl/word_wrap_line_breaker_unit.sv */
// a word is registered in the input stage, then its results are written to the queue
// throughput: one word per cycle; the line counters update in one step per word
// a word that closes two lines writes both of its results into the queue together,
// a four-entry result queue absorbs them and stalls input only when nearly full
// reset: counters and offsets zero, wrapping on, line width 80, queue empty
module word_wrap_line_breaker_unit #(
    parameter int unsigned MAX_TEXT_BYTES = wwlb_pkg::MAX_TEXT_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  wwlb_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output wwlb_pkg::out_item_t out_data
);
    import wwlb_pkg::*;

    logic       wrap_enable_reg;
    logic [7:0] line_width_reg;
    logic       s1_valid_reg, s1_valid_next;
    in_item_t   s1_data_reg;
    logic       accept;
    logic       fire;
    logic       room;
    push_t      push;

    assign fire     = s1_valid_reg && room;
    assign in_stall = s1_valid_reg && !room;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_enable_reg <= WRAP_ENABLE_RESET;
            line_width_reg  <= LINE_WIDTH_RESET;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WRAP_ENABLE: wrap_enable_reg <= cfg_data[0];
                    REG_LINE_WIDTH:  line_width_reg  <= cfg_data;
                    default:         ;
                endcase
            end
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= in_data;
    end

    wwlb_core #(
        .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (s1_data_reg),
        .wrap_enable (wrap_enable_reg),
        .line_width  (line_width_reg),
        .push        (push)
    );

    wwlb_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // the last word of a text always closes at least one line
    a_eot_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_data_reg.end_of_text |-> push.count != 2'd0)
        else $error("end of text produced no line");

    // two lines from one word only happen at end of text
    a_two_only_eot: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> s1_data_reg.end_of_text)
        else $error("double result without end of text");

    // nothing is pushed unless the input stage fires
    a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> push.count == 2'd0)
        else $error("result pushed without a word");

    // a stalled input stage is released once the queue has room
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && room |-> !in_stall)
        else $error("input stalled with queue room");

endmodule
